// ===== sv/sha512_hash_engine_defines.svh =====
// Assertion macros used by the SHA-512 engine core
`ifndef SHA512_HASH_ENGINE_DEFINES_SVH
`define SHA512_HASH_ENGINE_DEFINES_SVH

// Assert that an antecedent implies a consequent in the same cycle
`define SHE_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle
`define SHE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/she_pkg.sv =====
// Package: types, constants and round functions of the SHA-512 engine
package she_pkg;

    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned ROUNDS      = 80;
    localparam int unsigned DIGEST_WORDS = 8;

    typedef logic [63:0] word_t;

    // Queue entry: one word for the block buffer plus control
    typedef struct packed {
        word_t word;
        logic  blk_end;   // word closes a block
        logic  msg_end;   // block closes the message
    } qent_t;

    typedef enum logic [1:0] {
        FE_TAKE,
        FE_PAD,
        FE_LEN
    } fe_state_t;

    typedef enum logic [1:0] {
        BE_FILL,
        BE_ROUND,
        BE_ADD,
        BE_OUT
    } be_state_t;

    localparam word_t PAD_WORD = 64'h8000000000000000;

    localparam word_t INIT_H [DIGEST_WORDS] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam word_t ROUND_K [ROUNDS] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    function automatic word_t rotr(input word_t x, input int unsigned n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        big_sigma0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        big_sigma1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        small_sigma0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        small_sigma1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
    endfunction

endpackage

// ===== sv/sha512_hash_engine.sv =====
// Top level: SHA-512 engine with padding front end, queue and compression core
//  channel | ports                                         | direction
//  input   | s_message_word, s_valid_bytes, s_last_word    | in, s_valid/s_ready
//  result  | m_digest_word, m_digest_index, m_digest_last  | out, m_valid/m_ready
// Each 16-word block is filled into the core, which then runs the 80 rounds and
// the add; the core takes no new words while it runs rounds, add or output.
// Padding adds two to eighteen marker/zero/length words at the end of a message.
// Eight digest transactions follow the final block; reset is synchronous.
// Either side may stall; the queue lets the front end run ahead by two words.
module sha512_hash_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [63:0] s_message_word,
    input  logic [3:0]  s_valid_bytes,
    input  logic        s_last_word,
    input  logic        s_valid,
    output logic        s_ready,
    output logic [63:0] m_digest_word,
    output logic [2:0]  m_digest_index,
    output logic        m_digest_last,
    output logic        m_valid,
    input  logic        m_ready
);

    she_pkg::qent_t fq_data, qc_data;
    logic fq_valid, fq_ready, qc_valid, qc_ready;

    she_front u_front (
        .aclk, .aresetn, .s_message_word, .s_valid_bytes, .s_last_word,
        .s_valid, .s_ready,
        .q_data(fq_data), .q_valid(fq_valid), .q_ready(fq_ready)
    );

    she_queue u_queue (
        .aclk, .aresetn,
        .in_data(fq_data), .in_valid(fq_valid), .in_ready(fq_ready),
        .out_data(qc_data), .out_valid(qc_valid), .out_ready(qc_ready)
    );

    she_core u_core (
        .aclk, .aresetn,
        .q_data(qc_data), .q_valid(qc_valid), .q_ready(qc_ready),
        .m_digest_word, .m_digest_index, .m_digest_last, .m_valid, .m_ready
    );

endmodule

// ===== sv/she_front.sv =====
// Front end: accepts message words, counts length, inserts padding words
module she_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [63:0]          s_message_word,
    input  logic [3:0]           s_valid_bytes,
    input  logic                 s_last_word,
    input  logic                 s_valid,
    output logic                 s_ready,
    output she_pkg::qent_t       q_data,
    output logic                 q_valid,
    input  logic                 q_ready
);

    she_pkg::fe_state_t state_reg, state_next;
    logic [3:0]  pos_reg, pos_next;
    logic [63:0] len_reg, len_next;
    logic [3:0]  vb_sat;
    logic [63:0] mask;
    logic [63:0] padded;
    logic [63:0] add_bits;
    logic        pad_first_reg;

    always_comb begin
        vb_sat = (s_valid_bytes > 4'd8) ? 4'd8 : s_valid_bytes;
        if (vb_sat == 4'd0) begin
            mask = '0;
        end else begin
            mask = ~64'd0 << (7'd64 - {vb_sat, 3'b000});
        end
        padded = (s_message_word & mask) | (64'h80 << (6'd56 - {vb_sat[2:0], 3'b000}));
        add_bits = s_last_word ? {57'd0, vb_sat, 3'b000} : 64'd64;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= she_pkg::FE_TAKE;
            pos_reg   <= '0;
            len_reg   <= '0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        s_ready    = 1'b0;
        q_valid    = 1'b0;
        q_data     = '0;
        case (state_reg)
            she_pkg::FE_TAKE: begin
                s_ready        = q_ready;
                q_valid        = s_valid;
                q_data.word    = (s_last_word && vb_sat != 4'd8) ? padded : s_message_word;
                q_data.blk_end = (pos_reg == 4'd15);
                if (s_valid && q_ready) begin
                    pos_next = pos_reg + 4'd1;
                    len_next = len_reg + add_bits;
                    if (s_last_word) begin
                        if (vb_sat == 4'd8) begin
                            state_next = she_pkg::FE_PAD;
                        end else if (pos_reg == 4'd13) begin
                            state_next = she_pkg::FE_LEN;
                        end else begin
                            state_next = she_pkg::FE_PAD;
                        end
                    end
                end
            end
            she_pkg::FE_PAD: begin
                q_valid        = 1'b1;
                q_data.word    = pad_first_reg ? she_pkg::PAD_WORD : 64'd0;
                q_data.blk_end = (pos_reg == 4'd15);
                if (q_ready) begin
                    pos_next = pos_reg + 4'd1;
                    if (pos_reg == 4'd13) begin
                        state_next = she_pkg::FE_LEN;
                    end
                end
            end
            she_pkg::FE_LEN: begin
                q_valid        = 1'b1;
                q_data.word    = (pos_reg == 4'd15) ? len_reg : 64'd0;
                q_data.blk_end = (pos_reg == 4'd15);
                q_data.msg_end = (pos_reg == 4'd15);
                if (q_ready) begin
                    pos_next = pos_reg + 4'd1;
                    if (pos_reg == 4'd15) begin
                        state_next = she_pkg::FE_TAKE;
                        len_next   = '0;
                    end
                end
            end
            default: begin
                state_next = she_pkg::FE_TAKE;
            end
        endcase
    end

    // The first pad word after a full last word carries the marker byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pad_first_reg <= 1'b0;
        end else if (state_reg == she_pkg::FE_TAKE && s_valid && q_ready) begin
            pad_first_reg <= s_last_word && (vb_sat == 4'd8);
        end else if (q_valid && q_ready) begin
            pad_first_reg <= 1'b0;
        end
    end

endmodule

// ===== sv/she_queue.sv =====
// Two-entry queue between front end and compression back end
module she_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  she_pkg::qent_t in_data,
    input  logic           in_valid,
    output logic           in_ready,
    output she_pkg::qent_t out_data,
    output logic           out_valid,
    input  logic           out_ready
);

    she_pkg::qent_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== sv/she_core.sv =====
// Back end: block buffer, 80-round compression, digest output
module she_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  she_pkg::qent_t q_data,
    input  logic           q_valid,
    output logic           q_ready,
    output logic [63:0]    m_digest_word,
    output logic [2:0]     m_digest_index,
    output logic           m_digest_last,
    output logic           m_valid,
    input  logic           m_ready
);

`include "sha512_hash_engine_defines.svh"

    she_pkg::be_state_t state_reg, state_next;
    she_pkg::word_t w_reg [16];
    she_pkg::word_t h_reg [8];
    she_pkg::word_t v_reg [8];
    logic [3:0] fill_reg;
    logic [6:0] rnd_reg;
    logic [2:0] oidx_reg;
    logic       msg_end_reg;

    she_pkg::word_t w_new, t1, t2, wt;
    logic take;

    always_comb begin
        w_new = she_pkg::small_sigma1(w_reg[14]) + w_reg[9]
              + she_pkg::small_sigma0(w_reg[1]) + w_reg[0];
        wt = w_reg[0];
        t1 = v_reg[7] + she_pkg::big_sigma1(v_reg[4])
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + she_pkg::ROUND_K[rnd_reg] + wt;
        t2 = she_pkg::big_sigma0(v_reg[0])
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    assign take           = (state_reg == she_pkg::BE_FILL) && q_valid;
    assign q_ready        = (state_reg == she_pkg::BE_FILL);
    assign m_valid        = (state_reg == she_pkg::BE_OUT);
    assign m_digest_word  = h_reg[oidx_reg];
    assign m_digest_index = oidx_reg;
    assign m_digest_last  = (oidx_reg == 3'd7);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            she_pkg::BE_FILL:  if (take && q_data.blk_end) state_next = she_pkg::BE_ROUND;
            she_pkg::BE_ROUND: if (rnd_reg == 7'd79) state_next = she_pkg::BE_ADD;
            she_pkg::BE_ADD:   state_next = msg_end_reg ? she_pkg::BE_OUT : she_pkg::BE_FILL;
            she_pkg::BE_OUT:   if (m_ready && oidx_reg == 3'd7) state_next = she_pkg::BE_FILL;
            default:           state_next = she_pkg::BE_FILL;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= she_pkg::BE_FILL;
            fill_reg    <= '0;
            rnd_reg     <= '0;
            oidx_reg    <= '0;
            msg_end_reg <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= she_pkg::INIT_H[i];
            end
        end else begin
            state_reg <= state_next;
            case (state_reg)
                she_pkg::BE_FILL: begin
                    if (take) begin
                        fill_reg <= fill_reg + 4'd1;
                        msg_end_reg <= q_data.msg_end;
                        if (q_data.blk_end) begin
                            for (int i = 0; i < 8; i++) begin
                                v_reg[i] <= h_reg[i];
                            end
                        end
                    end
                end
                she_pkg::BE_ROUND: begin
                    rnd_reg <= (rnd_reg == 7'd79) ? 7'd0 : rnd_reg + 7'd1;
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                end
                she_pkg::BE_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                end
                she_pkg::BE_OUT: begin
                    if (m_ready) begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7) begin
                            msg_end_reg <= 1'b0;
                            for (int i = 0; i < 8; i++) begin
                                h_reg[i] <= she_pkg::INIT_H[i];
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Schedule window shifts in on fill and advances each round
    always_ff @(posedge aclk) begin
        if (take || state_reg == she_pkg::BE_ROUND) begin
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= take ? q_data.word : w_new;
        end
    end

    `SHE_ASSERT_IMP(a_out_only_out, aclk, aresetn, m_valid, state_reg == she_pkg::BE_OUT, "output valid outside output state")
    `SHE_ASSERT_NEXT(a_round_adv, aclk, aresetn, state_reg == she_pkg::BE_ROUND && rnd_reg != 7'd79, rnd_reg == $past(rnd_reg) + 7'd1, "round counter skipped")
    `SHE_ASSERT_IMP(a_rnd_idle, aclk, aresetn, state_reg == she_pkg::BE_FILL, rnd_reg == 7'd0, "round counter not cleared")
    `SHE_ASSERT_NEXT(a_blk_round, aclk, aresetn, take && q_data.blk_end, state_reg == she_pkg::BE_ROUND, "block end did not start rounds")

endmodule

// ===== bench/testbench.sv =====
// Testbench for the SHA-512 hash engine: directed and random messages checked against a SHA-512 model
module testbench;

    localparam int unsigned CYCLE_LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [63:0] s_message_word = '0;
    logic [3:0]  s_valid_bytes = '0;
    logic        s_last_word = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] m_digest_word;
    logic [2:0]  m_digest_index;
    logic        m_digest_last;
    logic        m_valid;
    logic        m_ready = 1'b0;

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    bit          stimulus_done = 1'b0;
    bit          no_idle = 1'b0;
    bit          hold_off = 1'b0;

    typedef struct packed {
        she_pkg::word_t word;
        logic [2:0]     index;
        logic           last;
    } digest_t;

    task automatic report(input string what, input she_pkg::word_t got,
                          input she_pkg::word_t want);
        $display("digest error: %s got %h want %h", what, got, want);
        error_count++;
    endtask

    class digest_scoreboard;
        she_pkg::word_t hash_state[8];
        she_pkg::word_t block_words[16];
        int unsigned    block_fill;
        logic [63:0]    bit_length;
        digest_t        pending[$];

        function new();
            restart();
        endfunction

        function void restart();
            foreach (hash_state[i]) hash_state[i] = she_pkg::INIT_H[i];
            block_fill = 0;
            bit_length = '0;
        endfunction

        function she_pkg::word_t ror(input she_pkg::word_t x, input int unsigned n);
            return (x >> n) | (x << (64 - n));
        endfunction

        function void compress();
            she_pkg::word_t w[80];
            she_pkg::word_t v[8];
            she_pkg::word_t t1, t2;
            for (int t = 0; t < 80; t++) begin
                if (t < 16) begin
                    w[t] = block_words[t];
                end else begin
                    w[t] = (ror(w[t-2], 19) ^ ror(w[t-2], 61) ^ (w[t-2] >> 6)) + w[t-7]
                         + (ror(w[t-15], 1) ^ ror(w[t-15], 8) ^ (w[t-15] >> 7)) + w[t-16];
                end
            end
            foreach (v[i]) v[i] = hash_state[i];
            for (int t = 0; t < 80; t++) begin
                t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + she_pkg::ROUND_K[t] + w[t];
                t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            foreach (v[i]) hash_state[i] += v[i];
        endfunction

        function void append(input she_pkg::word_t w);
            block_words[block_fill] = w;
            if (block_fill == 15) begin
                compress();
                block_fill = 0;
            end else begin
                block_fill++;
            end
        endfunction

        function void note_input(input she_pkg::word_t word, input logic [3:0] count,
                                 input logic last);
            int unsigned n;
            she_pkg::word_t mask;
            if (!last) begin
                bit_length += 64;
                append(word);
                return;
            end
            n = (count > 8) ? 8 : count;
            bit_length += n * 8;
            if (n == 8) begin
                append(word);
                append(she_pkg::PAD_WORD);
            end else begin
                mask = (n == 0) ? '0 : ~64'd0 << (64 - 8 * n);
                append((word & mask) | (64'h80 << (56 - 8 * n)));
            end
            if (block_fill == 15) append('0);
            while (block_fill != 14) append('0);
            append('0);
            append(bit_length);
            for (int i = 0; i < 8; i++) pending.push_back({hash_state[i], 3'(i), i == 7});
            restart();
        endfunction

        task check_result(input she_pkg::word_t word, input logic [2:0] index,
                          input logic last);
            digest_t want;
            if (pending.size() == 0) begin
                report("unexpected word", word, '0);
                return;
            end
            want = pending.pop_front();
            if (word !== want.word) report("digest_word", word, want.word);
            if (index !== want.index) report("digest_index", 64'(index), 64'(want.index));
            if (last !== want.last) report("digest_last", 64'(last), 64'(want.last));
        endtask
    endclass

    digest_scoreboard digests = new();

    sha512_hash_engine i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_message_word(s_message_word), .s_valid_bytes(s_valid_bytes),
        .s_last_word(s_last_word), .s_valid(s_valid), .s_ready(s_ready),
        .m_digest_word(m_digest_word), .m_digest_index(m_digest_index),
        .m_digest_last(m_digest_last), .m_valid(m_valid), .m_ready(m_ready)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sha512_hash_engine: mismatch");
            $finish;
        end
        if (aresetn && s_valid && s_ready) digests.note_input(s_message_word, s_valid_bytes,
                                                              s_last_word);
        if (aresetn && m_valid && m_ready) digests.check_result(m_digest_word, m_digest_index,
                                                                m_digest_last);
    end

    always @(negedge aclk) begin
        if (hold_off) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= no_idle || ($urandom_range(99) >= 37);
        end
    end

    task automatic send_word(input she_pkg::word_t word, input logic [3:0] count,
                             input logic last);
        while (!no_idle && $urandom_range(99) < 37) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_message_word <= word;
        s_valid_bytes <= count;
        s_last_word <= last;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic she_pkg::word_t random_word();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send_message(input int unsigned len, input logic [3:0] count);
        for (int i = 0; i < len; i++) send_word(random_word(), 4'($urandom_range(15)), 1'b0);
        send_word(random_word(), count, 1'b1);
    endtask

    initial begin
        int unsigned sent;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        send_word('0, 4'd0, 1'b1);
        send_word('1, 4'd8, 1'b1);
        send_word(64'hffffffffffffffff, 4'd15, 1'b1);
        send_word(64'h0123456789abcdef, 4'd3, 1'b0);
        send_word(64'hfedcba9876543210, 4'd1, 1'b1);
        send_message(13, 4'd7);
        send_message(14, 4'd8);
        sent = 34;
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(posedge aclk);
                hold_off = 1'b0;
            end
            send_message(30, 4'd5);
        join
        sent += 31;
        no_idle = 1'b1;
        send_message(15, 4'($urandom_range(8)));
        no_idle = 1'b0;
        sent += 16;
        while (sent < 120) begin
            int unsigned len;
            len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(17);
            send_message(len, 4'($urandom_range(9) == 0 ? $urandom_range(15) : $urandom_range(8)));
            sent += len + 1;
        end
        s_valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    initial begin
        wait (stimulus_done);
        while (digests.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (error_count == 0) begin
            $display("sha512_hash_engine: match");
        end else begin
            $display("sha512_hash_engine: mismatch");
        end
        $finish;
    end
endmodule
